@@ design/bba_pkg.sv @@
// bba_pkg: shared types, codes and sizing constants of the bitmap block allocator
// used by every module in the design folder; no dependencies
package bba_pkg;

  localparam int unsigned BLOCK_BYTES = 8192;  // power of two, 8 to 65536
  localparam int unsigned NUM_BLOCKS  = 32;    // 1 to 64

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned MAP_W       = 64;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam logic [ADDR_W-1:0] POOL_SPAN =
    ADDR_W'(longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES));

  // bits of the map that belong to the pool
  localparam logic [MAP_W-1:0] POOL_MASK =
    (NUM_BLOCKS >= MAP_W) ? {MAP_W{1'b1}} : ((MAP_W'(1) << NUM_BLOCKS) - MAP_W'(1));

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [MAP_W-1:0]  map_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // operation codes on the input channel
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADADDR = 2'd2
  } status_e;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_BAD,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e kind;
    idx_t  idx;
  } cmd_t;

endpackage

@@ design/bitmap_block_allocator.sv @@
// bitmap_block_allocator: fixed-size block allocator over a 64-bit free map
// the front register loads on the request transaction, then command queue, then
// result register; throughput: one request per cycle while m_axis_tready holds,
// set by the combinational lowest-free search and map update
// reset: every block free, pool base 0, queue and result register empty
module bitmap_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [47:0]   cfg_wdata_i,     // pool_base[47:0]
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,    // address[47:0]
  input  logic [1:0]    s_axis_tuser,    // operation[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,    // block_index[5:0], block_address[53:6],
                                         // free_map[117:54], zero[119:118]
  output logic [1:0]    m_axis_tuser     // status[1:0]
);
  import bba_pkg::*;

  addr_t pool_base_q;
  logic  f_valid, f_ready;
  cmd_t  f_cmd;
  logic  b_valid, b_ready;
  cmd_t  b_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_we_i) begin
      pool_base_q <= cfg_wdata_i;
    end
  end

  bba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pool_base_i   (pool_base_q),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_o         (f_cmd)
  );

  bba_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  bba_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (b_valid),
    .cmd_ready_o   (b_ready),
    .cmd_i         (b_cmd),
    .pool_base_i   (pool_base_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ design/bba_front.sv @@
// bba_front: accepts requests, decodes the operation and checks free addresses
// depends on bba_pkg; feeds bba_fifo
module bba_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,   // address[47:0]
  input  logic [1:0]           s_axis_tuser,   // operation[1:0]
  input  bba_pkg::addr_t       pool_base_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output bba_pkg::cmd_t        cmd_o
);
  import bba_pkg::*;

  logic  vld_q, vld_d;
  cmd_t  cmd_q, cmd_d;
  addr_t addr, offset;
  logic  bad_addr;

  assign addr   = s_axis_tdata;
  assign offset = addr - pool_base_i;

  always_comb begin
    bad_addr = (addr == '0) || (addr < pool_base_i) || (offset >= POOL_SPAN) ||
               (offset[BLOCK_SHIFT-1:0] != '0);
    cmd_d.idx = '0;
    case (s_axis_tuser)
      OP_ALLOC: begin
        cmd_d.kind = KIND_ALLOC;
      end
      OP_FREE: begin
        if (bad_addr) begin
          cmd_d.kind = KIND_BAD;
        end else begin
          cmd_d.kind = KIND_FREE;
          cmd_d.idx  = offset[BLOCK_SHIFT +: IDX_W];
        end
      end
      default: begin
        // read and the unused code both just report the map
        cmd_d.kind = KIND_READ;
      end
    endcase
  end

  assign s_axis_tready = !vld_q || cmd_ready_i;
  assign vld_d         = s_axis_tvalid || (vld_q && !cmd_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

@@ design/bba_fifo.sv @@
// bba_fifo: two-entry command queue between front and back
// depends on bba_pkg for the command type
module bba_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bba_pkg::cmd_t  push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bba_pkg::cmd_t  pop_cmd_o
);
  import bba_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_t       mem_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/bba_back.sv @@
// bba_back: owns the free map, carries out commands and holds the result register
// depends on bba_pkg; fed by bba_fifo
module bba_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  bba_pkg::cmd_t  cmd_i,
  input  bba_pkg::addr_t pool_base_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [119:0]   m_axis_tdata,   // block_index[5:0], block_address[53:6],
                                         // free_map[117:54], zero[119:118]
  output logic [1:0]     m_axis_tuser    // status[1:0]
);
  import bba_pkg::*;

  map_t    map_q, map_d;
  logic    out_vld_q;
  status_e status_q, status_d;
  idx_t    idx_q, idx_d;
  addr_t   baddr_q, baddr_d;
  map_t    omap_q;
  idx_t    low_idx;
  logic    found;
  logic    take;

  assign cmd_ready_o = !out_vld_q || m_axis_tready;
  assign take        = cmd_valid_i && cmd_ready_o;

  // lowest free block inside the pool
  always_comb begin
    found   = 1'b0;
    low_idx = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (map_q[i]) begin
        found   = 1'b1;
        low_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    map_d    = map_q;
    status_d = ST_OK;
    idx_d    = '0;
    baddr_d  = '0;
    case (cmd_i.kind)
      KIND_ALLOC: begin
        if (found) begin
          map_d[low_idx] = 1'b0;
          idx_d          = low_idx;
          baddr_d        = pool_base_i + (ADDR_W'(low_idx) << BLOCK_SHIFT);
        end else begin
          status_d = ST_NOMEM;
        end
      end
      KIND_FREE: begin
        map_d[cmd_i.idx] = 1'b1;
      end
      KIND_BAD: begin
        status_d = ST_BADADDR;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q     <= '1;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        map_q <= map_d;
      end
      if (cmd_ready_o) begin
        out_vld_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      baddr_q  <= baddr_d;
      omap_q   <= map_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, omap_q, baddr_q, idx_q};

  // map bits outside the pool never leave the free state
  a_outside_pool_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_q | POOL_MASK) == '1)
    else $error("map bit outside the pool was cleared");

  // a pending result always reports the current map
  a_result_map_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (omap_q == map_q))
    else $error("result map differs from the live map");

  // out of memory only when no pool block is free
  a_nomem_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q == ST_NOMEM) |-> ((omap_q & POOL_MASK) == '0))
    else $error("out of memory reported with a free block");

  // a successful allocation leaves its block taken in the reported map
  a_alloc_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.kind == KIND_ALLOC && found) |=> !omap_q[idx_q])
    else $error("allocated block still marked free");

endmodule
